/* hw/rtl/icf_pkg.sv */
// icf_pkg: shared types, kernel tables and weight lookup for the image convolution filter
// no dependencies; used by the cells and the top level through scoped names

package icf_pkg;

  // fixed widths of the datapath
  localparam int KW        = 12;    // kernel weight width, signed
  localparam int SUM_W     = 24;    // accumulator width, signed
  localparam int NORM_W    = 13;    // normaliser width, signed
  localparam int ROW_W     = 10;    // line counter width
  localparam int MAX_LINES = 1024;  // lines per frame ceiling

  // register map
  localparam logic [1:0] REG_KSEL   = 2'd0;
  localparam logic [1:0] REG_NORM   = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  // kernels, column-major (entry column * size + row); 3x3 kernels use the first nine entries
  localparam logic signed [KW-1:0] KTAB [8][25] = '{
    '{12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd1, 12'sd0, 12'sd0, 12'sd0, 12'sd0,
      12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0,
      12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0},
    '{12'sd1, 12'sd1, 12'sd1, 12'sd1, 12'sd1, 12'sd1, 12'sd1, 12'sd1, 12'sd1,
      12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0,
      12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0},
    '{12'sd5, 12'sd5, 12'sd5, 12'sd5, 12'sd5, 12'sd5, 12'sd5, 12'sd5, 12'sd5,
      12'sd5, 12'sd5, 12'sd5, 12'sd5, 12'sd5, 12'sd5, 12'sd5, 12'sd5, 12'sd5,
      12'sd5, 12'sd5, 12'sd5, 12'sd5, 12'sd5, 12'sd5, 12'sd5},
    '{12'sd0, -12'sd1, 12'sd0, -12'sd1, 12'sd5, -12'sd1, 12'sd0, -12'sd1, 12'sd0,
      12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0,
      12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0},
    '{12'sd0, 12'sd1, 12'sd0, 12'sd1, -12'sd4, 12'sd1, 12'sd0, 12'sd1, 12'sd0,
      12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0,
      12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0},
    '{12'sd5, 12'sd10, 12'sd20, 12'sd10, 12'sd5,
      12'sd10, 12'sd100, 12'sd200, 12'sd200, 12'sd10,
      12'sd20, 12'sd200, -12'sd1500, 12'sd200, 12'sd20,
      12'sd10, 12'sd100, 12'sd200, 12'sd100, 12'sd10,
      12'sd5, 12'sd10, 12'sd20, 12'sd10, 12'sd5},
    '{12'sd1, 12'sd4, 12'sd6, 12'sd4, 12'sd1,
      12'sd4, 12'sd16, 12'sd24, 12'sd16, 12'sd4,
      12'sd6, 12'sd24, -12'sd476, 12'sd24, 12'sd6,
      12'sd4, 12'sd16, 12'sd24, 12'sd16, 12'sd4,
      12'sd1, 12'sd4, 12'sd6, 12'sd4, 12'sd1},
    '{12'sd1, 12'sd4, 12'sd6, 12'sd4, 12'sd1,
      12'sd4, 12'sd16, 12'sd24, 12'sd16, 12'sd4,
      12'sd6, 12'sd24, 12'sd36, 12'sd24, 12'sd6,
      12'sd4, 12'sd16, 12'sd24, 12'sd16, 12'sd4,
      12'sd1, 12'sd4, 12'sd6, 12'sd4, 12'sd1}
  };

  localparam logic [2:0] KDIM [8] = '{3'd3, 3'd3, 3'd5, 3'd3, 3'd3, 3'd5, 3'd5, 3'd5};

  localparam logic signed [NORM_W-1:0] KNORM [8] = '{
    13'sd1, 13'sd9, 13'sd125, 13'sd1, 13'sd1, 13'sd1, -13'sd256, 13'sd256
  };

  // control handed from the sequencer to every window cell
  typedef struct packed {
    logic shift;  // take a new pixel in at the right end
    logic rot;    // rotate the row by one place during accumulation
  } cell_ctrl_t;

  // kernel selection after falling back to identity when it exceeds the window
  function automatic logic [2:0] eff_sel(input logic [2:0] sel, input int ks);
    logic [2:0] r;
    r = sel;
    if (int'(KDIM[sel]) > ks) r = 3'd0;
    return r;
  endfunction

  // weight seen by window row wr, column wc for the selected kernel
  function automatic logic signed [KW-1:0] kweight(input logic [2:0] sel, input int wr,
                                                  input int wc, input int ks);
    logic [2:0] sl;
    int         s;
    int         off;
    logic [4:0] idx;
    sl  = eff_sel(sel, ks);
    s   = int'(KDIM[sl]);
    off = ks - s;
    if (wr < off || wc < off) return '0;
    idx = 5'((wc - off) * s + (wr - off));
    return KTAB[sl][idx];
  endfunction

endpackage

/* hw/rtl/icf_if.sv */
// icf_if: valid/ready channel interfaces for pixel input and filtered output
// no dependencies

interface icf_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_value;
  logic       frame_start;
  modport source (output valid, output pixel_value, output frame_start, input ready);
  modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface

interface icf_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_value;
  logic       out_last;
  modport source (output valid, output out_value, output out_last, input ready);
  modport sink   (input valid, input out_value, input out_last, output ready);
endinterface

/* hw/rtl/image_conv_kernel_filter_top.sv */
// image_conv_kernel_filter_top: streaming 2d convolution with line buffers and window cells
// depends on icf_pkg, icf_if, icf_line_bank, icf_win_cell, icf_divider
//
// channel   dir  handshake        payload
// pix_i     in   valid/ready      pixel_value[7:0], frame_start
// res_o     out  valid/ready      out_value[7:0], out_last
// apb       in   psel/penable     paddr[3:0], pwdata[31:0], prdata[31:0]
//
// a pixel with no result is accepted, loaded and back in idle; one with a result runs through
// accept, load, one window column a cycle, divider start, the quotient bits, done, hand-over
// after reset the line buffers are cleared at every address while pix_i is not ready
// a result waits in the output register; the next pixel is taken meanwhile, and only a
// second result stalls behind an untaken one

module image_conv_kernel_filter_top #(
  parameter int MAX_WIDTH   = 1024,
  parameter int KERNEL_SIZE = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  icf_pix_if.sink     pix_i,
  icf_res_if.source   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int KS    = KERNEL_SIZE;
  localparam int LB    = KS - 1;
  localparam int BW    = $clog2(LB);
  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int WW    = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
  localparam int SUM_W = icf_pkg::SUM_W;
  localparam int NW    = icf_pkg::NORM_W;
  localparam int RW    = icf_pkg::ROW_W;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_LOAD, ST_MAC, ST_DIV, ST_FIN
  } state_e;

  // configuration registers
  logic [2:0]           ksel_q;
  logic signed [NW-1:0] norm_q;
  logic [10:0]          width_q;
  logic [10:0]          height_q;
  logic                 cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ksel_q   <= '0;
      norm_q   <= '0;
      width_q  <= 11'd1024;
      height_q <= 11'd1024;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        icf_pkg::REG_KSEL:   ksel_q   <= pwdata[2:0];
        icf_pkg::REG_NORM:   norm_q   <= pwdata[NW-1:0];
        icf_pkg::REG_WIDTH:  width_q  <= pwdata[10:0];
        icf_pkg::REG_HEIGHT: height_q <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr[3:2])
      icf_pkg::REG_KSEL:   prdata = {29'd0, ksel_q};
      icf_pkg::REG_NORM:   prdata = {19'd0, norm_q};
      icf_pkg::REG_WIDTH:  prdata = {21'd0, width_q};
      icf_pkg::REG_HEIGHT: prdata = {21'd0, height_q};
      default:             prdata = '0;
    endcase
  end

  // effective frame size and kernel
  logic [WW-1:0]        img_w;
  logic [10:0]          img_h;
  logic [2:0]           sel_eff;
  logic [2:0]           kdim;
  logic signed [NW-1:0] norm;

  always_comb begin
    if (width_q == '0)                        img_w = WW'(1);
    else if (WW'(width_q) > WW'(MAX_WIDTH))   img_w = WW'(MAX_WIDTH);
    else                                      img_w = WW'(width_q);
    if (height_q == '0)                                 img_h = 11'd1;
    else if (height_q > 11'(icf_pkg::MAX_LINES))        img_h = 11'(icf_pkg::MAX_LINES);
    else                                                img_h = height_q;
  end

  assign sel_eff = icf_pkg::eff_sel(ksel_q, KS);
  assign kdim    = icf_pkg::KDIM[sel_eff];
  assign norm    = (norm_q != '0) ? norm_q : icf_pkg::KNORM[sel_eff];

  // sequencer state
  state_e              state_q;
  logic [AW-1:0]       clr_q;
  logic [AW-1:0]       col_q;
  logic [RW-1:0]       row_q;
  logic [BW-1:0]       base_q;
  logic [BW-1:0]       base_lat_q;
  logic [7:0]          pix_q;
  logic                emit_q;
  logic                last_q;
  logic [2:0]          step_q;
  logic signed [SUM_W-1:0] acc_q;
  logic                neg_q;
  logic                div_go_q;
  logic [7:0]          res_val_q;
  logic                res_valid_q;
  logic [7:0]          out_val_q;
  logic                out_last_q;

  // position of the incoming pixel
  logic                in_fire;
  logic [AW-1:0]       col;
  logic [RW-1:0]       row;
  logic [BW-1:0]       base;
  logic                emit;
  logic                last;
  logic                col_end;
  logic                row_end;

  assign pix_i.ready = (state_q == ST_IDLE);
  assign in_fire     = pix_i.valid && pix_i.ready;
  assign col         = pix_i.frame_start ? '0 : col_q;
  assign row         = pix_i.frame_start ? '0 : row_q;
  assign base        = pix_i.frame_start ? '0 : base_q;
  assign col_end     = (WW'(col) + WW'(1)) >= img_w;
  assign row_end     = (11'(row) + 11'd1) >= img_h;
  assign emit        = ((WW'(col) + WW'(1)) >= WW'(kdim)) && ((11'(row) + 11'd1) >= 11'(kdim));
  assign last        = ((WW'(col) + WW'(1)) == img_w) && ((11'(row) + 11'd1) == img_h);

  // line buffers
  logic [7:0] rdata [LB];

  for (genvar b = 0; b < LB; b++) begin : g_bank
    logic          we;
    logic [AW-1:0] waddr;
    assign we    = (state_q == ST_CLEAR) || (in_fire && base == BW'(b));
    assign waddr = (state_q == ST_CLEAR) ? clr_q : col;
    icf_line_bank #(.DEPTH(MAX_WIDTH)) u_bank (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (waddr),
      .wdata_i ((state_q == ST_CLEAR) ? 8'd0 : pix_i.pixel_value),
      .raddr_i (col),
      .rdata_o (rdata[b])
    );
  end

  // chain of window cells; row r takes line buffer (base + r) mod LB, last row the new pixel
  icf_pkg::cell_ctrl_t     cctrl;
  logic signed [SUM_W-1:0] psum [KS+1];

  assign cctrl.shift = (state_q == ST_LOAD);
  assign cctrl.rot   = (state_q == ST_MAC);
  assign psum[0]     = '0;

  for (genvar r = 0; r < KS; r++) begin : g_cell
    logic [7:0] pnew;
    if (r < LB) begin : g_line
      logic [BW:0]   sum;
      logic [BW-1:0] idx;
      assign sum  = {1'b0, base_lat_q} + (BW+1)'(r);
      assign idx  = (sum >= (BW+1)'(LB)) ? BW'(sum - (BW+1)'(LB)) : BW'(sum);
      assign pnew = rdata[idx];
    end else begin : g_new
      assign pnew = pix_q;
    end
    icf_win_cell #(.KS(KS), .ROW(r)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (cctrl),
      .pix_new_i (pnew),
      .ksel_i    (ksel_q),
      .step_i    (step_q),
      .psum_i    (psum[r]),
      .psum_o    (psum[r+1])
    );
  end

  // division of the magnitudes, started once the last column is in the sum
  logic             div_start;
  logic             div_done;
  logic [SUM_W-1:0] quo;
  logic [SUM_W-1:0] acc_mag;
  logic [NW-1:0]    norm_mag;

  assign div_start = div_go_q;
  assign acc_mag   = acc_q[SUM_W-1] ? SUM_W'(-acc_q) : SUM_W'(acc_q);
  assign norm_mag  = norm[NW-1] ? NW'(-norm) : NW'(norm);

  icf_divider #(.NUM_W(SUM_W), .DEN_W(NW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (acc_mag),
    .den_i   (norm_mag),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  logic res_take;
  assign res_take = (state_q == ST_FIN) && (!res_valid_q || res_o.ready);

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      base_q      <= '0;
      base_lat_q  <= '0;
      step_q      <= '0;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      div_go_q    <= 1'b0;
      emit_q      <= 1'b0;
      last_q      <= 1'b0;
      res_val_q   <= '0;
      res_valid_q <= 1'b0;
      out_val_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      div_go_q <= (state_q == ST_MAC) && (step_q == 3'(KS - 1));
      if (res_take) begin
        res_valid_q <= 1'b1;
      end else if (res_valid_q && res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(MAX_WIDTH - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_fire) begin
            base_lat_q <= base;
            emit_q     <= emit;
            last_q     <= last;
            if (col_end) begin
              col_q <= '0;
              if (row_end) begin
                row_q  <= '0;
                base_q <= '0;
              end else begin
                row_q  <= row + 1'b1;
                base_q <= (base == BW'(LB - 1)) ? '0 : base + 1'b1;
              end
            end else begin
              col_q  <= col + 1'b1;
              row_q  <= row;
              base_q <= base;
            end
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          step_q  <= '0;
          acc_q   <= '0;
          state_q <= emit_q ? ST_MAC : ST_IDLE;
        end
        ST_MAC: begin
          acc_q  <= acc_q + psum[KS];
          step_q <= step_q + 1'b1;
          if (step_q == 3'(KS - 1)) state_q <= ST_DIV;
        end
        ST_DIV: begin
          neg_q <= acc_q[SUM_W-1] ^ norm[NW-1];
          if (div_done) begin
            if (neg_q)                       res_val_q <= 8'd0;
            else if (quo > SUM_W'(255))      res_val_q <= 8'd255;
            else                             res_val_q <= quo[7:0];
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (res_take) begin
            out_val_q   <= res_val_q;
            out_last_q  <= last_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // pixel register
  always_ff @(posedge clk_i) begin
    if (in_fire) pix_q <= pix_i.pixel_value;
  end

  assign res_o.valid     = res_valid_q;
  assign res_o.out_value = out_val_q;
  assign res_o.out_last  = out_last_q;

endmodule

/* hw/rtl/icf_line_bank.sv */
// icf_line_bank: one line buffer, single write port and registered read port
// no dependencies

module icf_line_bank #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [7:0]               rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  // read returns the old word when the same address is written
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/icf_win_cell.sv */
// icf_win_cell: one window row; shifts in pixels and adds its weighted tap to the sum chain
// depends on icf_pkg

module icf_win_cell #(
  parameter int KS  = 5,
  parameter int ROW = 0
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  icf_pkg::cell_ctrl_t                 ctrl_i,
  input  logic [7:0]                          pix_new_i,
  input  logic [2:0]                          ksel_i,
  input  logic [2:0]                          step_i,
  input  logic signed [icf_pkg::SUM_W-1:0]    psum_i,
  output logic signed [icf_pkg::SUM_W-1:0]    psum_o
);

  logic [7:0]                     pix_q [KS];
  logic signed [icf_pkg::KW-1:0]  weight;
  logic signed [icf_pkg::KW+8:0]  prod;

  // row shift on a new pixel, rotate during accumulation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KS; i++) pix_q[i] <= '0;
    end else if (ctrl_i.shift) begin
      for (int i = 0; i < KS - 1; i++) pix_q[i] <= pix_q[i+1];
      pix_q[KS-1] <= pix_new_i;
    end else if (ctrl_i.rot) begin
      for (int i = 0; i < KS - 1; i++) pix_q[i] <= pix_q[i+1];
      pix_q[KS-1] <= pix_q[0];
    end
  end

  // weighted tap of the current column
  assign weight = icf_pkg::kweight(ksel_i, ROW, int'(step_i), KS);
  assign prod   = $signed({1'b0, pix_q[0]}) * weight;
  assign psum_o = psum_i + icf_pkg::SUM_W'(prod);

endmodule

/* hw/rtl/icf_divider.sv */
// icf_divider: restoring unsigned divider, one quotient bit per cycle
// no dependencies

module icf_divider #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 13
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q;
  logic [DEN_W:0]   rem_q;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] diff;

  // shift in the next dividend bit and trial subtract
  assign rem_sh = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      if (!diff[DEN_W+1]) begin
        rem_q <= diff[DEN_W:0];
        quo_q <= {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

/* hw/rtl/icf_checker.sv */
// icf_checker: port-level assertions for the image convolution filter, bound to the top level
// depends on image_conv_kernel_filter_top

module icf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       pix_valid_i,
  input logic       pix_ready_i,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [7:0] res_value_i,
  input logic       res_last_i,
  input logic       pready_i
);

  // reset holds both channels quiet
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !res_valid_i && !pix_ready_i)
    else $error("channel active during reset");

  // one pixel at a time: no back-to-back acceptance
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_i && pix_ready_i |=> !pix_ready_i)
    else $error("pixel accepted while previous still in work");

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_value_i) && $stable(res_last_i))
    else $error("stalled result changed");

  // the register port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready_i)
    else $error("pready low");

endmodule

bind image_conv_kernel_filter_top icf_checker u_icf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pix_valid_i (pix_i.valid),
  .pix_ready_i (pix_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_value_i (res_o.out_value),
  .res_last_i  (res_o.out_last),
  .pready_i    (pready)
);
